// File: sv/es2cs_pkg.sv
// ----------------------------------------------------------------------------
// es2cs_pkg: shared types and constants for the epoch to calendar converter
// Stage record, division constants and the month offset table.
// ----------------------------------------------------------------------------
package es2cs_pkg;

  localparam int unsigned NumStages = 13;

  // Valid window: 0001-01-01 00:00:00 .. 9999-12-31 23:59:59
  localparam logic signed [38:0] SecLow     = -39'sd62135596800;
  localparam logic signed [38:0] SecHigh    = 39'sd253402300799;
  // Whole number of days (719162) to 0001-01-01, so floor division falls out
  localparam logic [38:0]        EpochShift = 39'd62135596800;

  localparam logic [19:0] MicroMax = 20'd999999;

  // Reciprocal estimates: floor(2^k / divisor), corrected by one compare later
  localparam logic [22:0] DayRecip   = 23'd6362914; // 2^32 / 675
  localparam logic [9:0]  DayDivHi   = 10'd675;     // 86400 >> 7
  localparam logic [6:0]  CenRecip   = 7'd104;      // 2^20 / 10000
  localparam logic [4:0]  EraRecip   = 5'd28;       // 2^22 / 146097
  localparam logic [5:0]  HourRecip  = 6'd36;       // 2^17 / 3600
  localparam logic [7:0]  HmRecip    = 8'd163;      // 2^14 / 100
  localparam logic [7:0]  Y4Recip    = 8'd179;      // 2^18 / 1460
  localparam logic [2:0]  Y100Recip  = 3'd7;        // 2^18 / 36524
  localparam logic [6:0]  MinRecip   = 7'd68;       // 2^12 / 60
  localparam logic [9:0]  YearRecip  = 10'd718;     // 2^18 / 365
  localparam logic [3:0]  MonRecip   = 4'd13;       // 2^11 / 153

  localparam logic [21:0] MarchShift = 22'd306;     // days 0001-01-01 to 0000-03-01 base
  localparam logic [17:0] DaysPerEra = 18'd146097;
  localparam logic [17:0] LastDoe    = 18'd146096;

  typedef struct packed {
    logic        err;
    logic [31:0] n;      // shifted seconds >> 7
    logic [6:0]  lo7;    // low seconds bits
    logic [21:0] days;   // day count from 0001-01-01 (estimate, then exact)
    logic [16:0] rem;    // second of day
    logic [21:0] z;      // day count from 0000-03-01
    logic [4:0]  era;
    logic [17:0] doe;    // day of era
    logic [4:0]  hr;
    logic [11:0] r2;     // second of hour
    logic [19:0] us;
    logic [6:0]  cen;
    logic [13:0] ur;     // microseconds within centisecond
    logic [6:0]  hm;
    logic [6:0]  mic;
    logic [6:0]  a;      // doe / 1460
    logic [2:0]  b;      // doe / 36524
    logic        c;      // doe / 146096
    logic [5:0]  mnt;
    logic [5:0]  sec;
    logic [17:0] t;
    logic [8:0]  yoe;    // year of era
    logic [8:0]  doy;    // day of March-based year
    logic [13:0] yr;
    logic [10:0] x;      // 5 * doy + 2
    logic [3:0]  mp;     // month counted from March
    logic [3:0]  mon;
    logic [4:0]  dom;
  } stage_t;

  // First day-of-year of each March-based month: (153 * mp + 2) / 5
  function automatic logic [8:0] month_base(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/epoch_seconds_to_calendar_stamp.sv
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat is stalled, so stall_o follows a stalled, occupied last stage.
// Reset clears the stage valid bits only.
// Data registers are not reset.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_stamp: signed Unix seconds to Gregorian stamp
// Thirteen-stage pipeline. Seconds are shifted to a non-negative count from
// 0001-01-01, split into day and second of day by a reciprocal multiply, then
// the day count goes through era / year / month extraction (the usual
// civil-from-days scheme). Every reciprocal-multiply division is an estimate
// multiply in one stage and a single compare-and-subtract correction in the next.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_stamp
  import es2cs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [38:0] epoch_seconds_i,
  input  logic [19:0]        micro_in_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [13:0]        year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_o,
  output logic [4:0]         hour_o,
  output logic [5:0]         minute_o,
  output logic [5:0]         second_o,
  output logic [6:0]         centis_o,
  output logic [6:0]         hundred_micros_o,
  output logic [6:0]         micros_o,
  output logic               range_error_o
);

  stage_t                 stg_q [NumStages];
  stage_t                 stg_d [NumStages];
  logic [NumStages-1:0]   vld_q, vld_d;
  logic                   adv;

  // Pipeline advances unless the output beat is held
  assign adv     = ~(vld_q[NumStages-1] & stall_i);
  assign stall_o = ~adv;
  assign valid_o = vld_q[NumStages-1];
  assign vld_d   = {vld_q[NumStages-2:0], valid_i};

  // ---- stage 0: range check, shift to 0001-01-01, saturate microseconds
  logic        s0_err;
  logic [38:0] s0_shift;
  logic [19:0] s0_us;
  assign s0_err   = (epoch_seconds_i < SecLow) || (epoch_seconds_i > SecHigh);
  assign s0_shift = epoch_seconds_i + EpochShift;
  assign s0_us    = (micro_in_i > MicroMax) ? MicroMax : micro_in_i;

  // ---- stage 1: day estimate (86400 = 128 * 675), centisecond estimate
  logic [54:0] s1_prod;
  logic [26:0] s1_cprod;
  assign s1_prod  = 55'(stg_q[0].n) * 55'(DayRecip);
  assign s1_cprod = 27'(stg_q[0].us) * 27'(CenRecip);

  // ---- stage 2: correct day count and centiseconds
  logic [31:0] s2_qm, s2_rw;
  logic [10:0] s2_r, s2_rc;
  logic        s2_hi;
  logic [20:0] s2_cm, s2_cw;
  logic [14:0] s2_cr;
  logic        s2_chi;
  assign s2_qm  = 32'(stg_q[1].days) * 32'(DayDivHi);
  assign s2_rw  = stg_q[1].n - s2_qm;
  assign s2_r   = s2_rw[10:0];
  assign s2_hi  = s2_r >= 11'(DayDivHi);
  assign s2_rc  = s2_hi ? s2_r - 11'(DayDivHi) : s2_r;
  assign s2_cm  = 21'(stg_q[1].cen) * 21'd10000;
  assign s2_cw  = 21'(stg_q[1].us) - s2_cm;
  assign s2_cr  = s2_cw[14:0];
  assign s2_chi = s2_cr >= 15'd10000;

  // ---- stage 3: era, hour and hundred-micro estimates
  logic [21:0] s3_z;
  logic [26:0] s3_eprod;
  logic [21:0] s3_hprod, s3_mprod;
  assign s3_z     = stg_q[2].days + MarchShift;
  assign s3_eprod = 27'(s3_z) * 27'(EraRecip);
  assign s3_hprod = 22'(stg_q[2].rem) * 22'(HourRecip);
  assign s3_mprod = 22'(stg_q[2].ur) * 22'(HmRecip);

  // ---- stage 4: correct era / day of era, hour, hundred-micros
  logic [21:0] s4_em, s4_dw;
  logic [18:0] s4_dr;
  logic        s4_ehi;
  logic [16:0] s4_hm, s4_rw;
  logic [12:0] s4_rr;
  logic        s4_hhi;
  logic [13:0] s4_um, s4_uw;
  logic [7:0]  s4_ur;
  logic        s4_uhi;
  assign s4_em  = 22'(stg_q[3].era) * 22'(DaysPerEra);
  assign s4_dw  = stg_q[3].z - s4_em;
  assign s4_dr  = s4_dw[18:0];
  assign s4_ehi = s4_dr >= 19'(DaysPerEra);
  assign s4_hm  = 17'(stg_q[3].hr) * 17'd3600;
  assign s4_rw  = stg_q[3].rem - s4_hm;
  assign s4_rr  = s4_rw[12:0];
  assign s4_hhi = s4_rr >= 13'd3600;
  assign s4_um  = 14'(stg_q[3].hm) * 14'd100;
  assign s4_uw  = stg_q[3].ur - s4_um;
  assign s4_ur  = s4_uw[7:0];
  assign s4_uhi = s4_ur >= 8'd100;

  // ---- stage 5: leap-cycle estimates, minute estimate
  logic [25:0] s5_aprod;
  logic [20:0] s5_bprod;
  logic [18:0] s5_mprod;
  assign s5_aprod = 26'(stg_q[4].doe) * 26'(Y4Recip);
  assign s5_bprod = 21'(stg_q[4].doe) * 21'(Y100Recip);
  assign s5_mprod = 19'(stg_q[4].r2) * 19'(MinRecip);

  // ---- stage 6: correct leap-cycle counts, minute and second
  logic [17:0] s6_aw, s6_bw;
  logic [11:0] s6_ra;
  logic [16:0] s6_rb;
  logic [11:0] s6_mw;
  logic [6:0]  s6_rm, s6_rmc;
  logic        s6_ahi, s6_bhi, s6_mhi;
  assign s6_aw  = stg_q[5].doe - 18'(stg_q[5].a) * 18'd1460;
  assign s6_ra  = s6_aw[11:0];
  assign s6_ahi = s6_ra >= 12'd1460;
  assign s6_bw  = stg_q[5].doe - 18'(stg_q[5].b) * 18'd36524;
  assign s6_rb  = s6_bw[16:0];
  assign s6_bhi = s6_rb >= 17'd36524;
  assign s6_mw  = stg_q[5].r2 - 12'(stg_q[5].mnt) * 12'd60;
  assign s6_rm  = s6_mw[6:0];
  assign s6_mhi = s6_rm >= 7'd60;
  assign s6_rmc = s6_mhi ? s6_rm - 7'd60 : s6_rm;

  // ---- stage 7: day of era less leap days, year-of-era estimate
  logic [17:0] s7_t;
  logic [27:0] s7_yprod;
  assign s7_t     = stg_q[6].doe - 18'(stg_q[6].a) + 18'(stg_q[6].b) - 18'(stg_q[6].c);
  assign s7_yprod = 28'(s7_t) * 28'(YearRecip);

  // ---- stage 8: correct year of era
  logic [17:0] s8_yw;
  logic [9:0]  s8_ry;
  logic        s8_yhi;
  assign s8_yw  = stg_q[7].t - 18'(stg_q[7].yoe) * 18'd365;
  assign s8_ry  = s8_yw[9:0];
  assign s8_yhi = s8_ry >= 10'd365;

  // ---- stage 9: day of year, March-based year
  logic [1:0]  s9_cent;
  logic [17:0] s9_yd, s9_dw;
  assign s9_cent = (stg_q[8].yoe >= 9'd300) ? 2'd3 :
                   (stg_q[8].yoe >= 9'd200) ? 2'd2 :
                   (stg_q[8].yoe >= 9'd100) ? 2'd1 : 2'd0;
  assign s9_yd   = 18'(stg_q[8].yoe) * 18'd365 + 18'(stg_q[8].yoe[8:2]) - 18'(s9_cent);
  assign s9_dw   = stg_q[8].doe - s9_yd;

  // ---- stage 10: month estimate
  logic [10:0] s10_x;
  logic [14:0] s10_mprod;
  assign s10_x     = 11'(stg_q[9].doy) * 11'd5 + 11'd2;
  assign s10_mprod = 15'(s10_x) * 15'(MonRecip);

  // ---- stage 11: correct month
  logic [10:0] s11_xw;
  logic [8:0]  s11_rx;
  logic        s11_mhi;
  assign s11_xw  = stg_q[10].x - 11'(stg_q[10].mp) * 11'd153;
  assign s11_rx  = s11_xw[8:0];
  assign s11_mhi = s11_rx >= 9'd153;

  // ---- stage 12: calendar month, day of month, January/February year carry
  logic [3:0] s12_mon;
  logic [8:0] s12_dw;
  assign s12_mon = (stg_q[11].mp < 4'd10) ? stg_q[11].mp + 4'd3 : stg_q[11].mp - 4'd9;
  assign s12_dw  = stg_q[11].doy - month_base(stg_q[11].mp) + 9'd1;

  always_comb begin
    stg_d[0]      = '0;
    stg_d[0].err  = s0_err;
    stg_d[0].n    = s0_shift[38:7];
    stg_d[0].lo7  = s0_shift[6:0];
    stg_d[0].us   = s0_us;

    stg_d[1]      = stg_q[0];
    stg_d[1].days = s1_prod[53:32];
    stg_d[1].cen  = s1_cprod[26:20];

    stg_d[2]      = stg_q[1];
    stg_d[2].days = stg_q[1].days + 22'(s2_hi);
    stg_d[2].rem  = {s2_rc[9:0], stg_q[1].lo7};
    stg_d[2].cen  = stg_q[1].cen + 7'(s2_chi);
    stg_d[2].ur   = s2_chi ? 14'(s2_cr - 15'd10000) : s2_cr[13:0];

    stg_d[3]      = stg_q[2];
    stg_d[3].z    = s3_z;
    stg_d[3].era  = s3_eprod[26:22];
    stg_d[3].hr   = s3_hprod[21:17];
    stg_d[3].hm   = s3_mprod[20:14];

    stg_d[4]      = stg_q[3];
    stg_d[4].era  = stg_q[3].era + 5'(s4_ehi);
    stg_d[4].doe  = s4_ehi ? 18'(s4_dr - 19'(DaysPerEra)) : s4_dr[17:0];
    stg_d[4].hr   = stg_q[3].hr + 5'(s4_hhi);
    stg_d[4].r2   = s4_hhi ? 12'(s4_rr - 13'd3600) : s4_rr[11:0];
    stg_d[4].hm   = stg_q[3].hm + 7'(s4_uhi);
    stg_d[4].mic  = s4_uhi ? 7'(s4_ur - 8'd100) : s4_ur[6:0];

    stg_d[5]      = stg_q[4];
    stg_d[5].a    = s5_aprod[24:18];
    stg_d[5].b    = s5_bprod[20:18];
    stg_d[5].c    = stg_q[4].doe == LastDoe;
    stg_d[5].mnt  = s5_mprod[17:12];

    stg_d[6]      = stg_q[5];
    stg_d[6].a    = stg_q[5].a + 7'(s6_ahi);
    stg_d[6].b    = stg_q[5].b + 3'(s6_bhi);
    stg_d[6].mnt  = stg_q[5].mnt + 6'(s6_mhi);
    stg_d[6].sec  = s6_rmc[5:0];

    stg_d[7]      = stg_q[6];
    stg_d[7].t    = s7_t;
    stg_d[7].yoe  = s7_yprod[26:18];

    stg_d[8]      = stg_q[7];
    stg_d[8].yoe  = stg_q[7].yoe + 9'(s8_yhi);

    stg_d[9]      = stg_q[8];
    stg_d[9].doy  = s9_dw[8:0];
    stg_d[9].yr   = 14'(stg_q[8].era) * 14'd400 + 14'(stg_q[8].yoe);

    stg_d[10]     = stg_q[9];
    stg_d[10].x   = s10_x;
    stg_d[10].mp  = s10_mprod[14:11];

    stg_d[11]     = stg_q[10];
    stg_d[11].mp  = stg_q[10].mp + 4'(s11_mhi);

    stg_d[12]     = stg_q[11];
    stg_d[12].mon = s12_mon;
    stg_d[12].dom = s12_dw[4:0];
    stg_d[12].yr  = stg_q[11].yr + 14'(s12_mon <= 4'd2);
    // out of range: every field but the flag reads zero
    if (stg_q[11].err) begin
      stg_d[12].mon = '0;
      stg_d[12].dom = '0;
      stg_d[12].yr  = '0;
      stg_d[12].hr  = '0;
      stg_d[12].mnt = '0;
      stg_d[12].sec = '0;
      stg_d[12].cen = '0;
      stg_d[12].hm  = '0;
      stg_d[12].mic = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q <= stg_d;
    end
  end

  assign year_o           = stg_q[NumStages-1].yr;
  assign month_o          = stg_q[NumStages-1].mon;
  assign day_o            = stg_q[NumStages-1].dom;
  assign hour_o           = stg_q[NumStages-1].hr;
  assign minute_o         = stg_q[NumStages-1].mnt;
  assign second_o         = stg_q[NumStages-1].sec;
  assign centis_o         = stg_q[NumStages-1].cen;
  assign hundred_micros_o = stg_q[NumStages-1].hm;
  assign micros_o         = stg_q[NumStages-1].mic;
  assign range_error_o    = stg_q[NumStages-1].err;

endmodule

// File: tb/epoch_seconds_to_calendar_stamp_test.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_stamp_test: self-checking bench for the converter
// A directed table of timestamps (epoch, window edges, leap and century days,
// negative seconds, out-of-window values, oversized microseconds) runs first.
// Three random phases follow with different idle mixes on each side. Every output
// beat is compared field by field with its typed stamp or a calendar predictor of its own.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_stamp_test;
  import es2cs_pkg::*;

  // Output beat as the predictor sees it; field order matches the port list.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  centis;
    logic [6:0]  hundred_micros;
    logic [6:0]  micros;
    logic        range_error;
  } stamp_t;

  // One row of the directed table. Where 'typed' is set, 'want' is taken as
  // written; otherwise the predictor supplies the expected stamp.
  typedef struct {
    logic signed [38:0] secs;
    logic [19:0]        us;
    bit                 typed;
    stamp_t             want;
  } row_t;

  localparam int unsigned QuietLimit  = 2000;  // cycles with no beat on either side
  localparam int unsigned LongHold    = 400;   // receiver hold-off, well past the depth
  localparam int unsigned PerPhase    = 510;
  localparam longint      SecsPerDay  = 86400;
  localparam longint      DaysBefore  = 719162; // 0001-01-01 to 1970-01-01
  localparam longint      DaySpan     = 3652059; // days in years 1..9999

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic signed [38:0] epoch_seconds_i = '0;
  logic [19:0]        micro_in_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [13:0]        year_o;
  logic [3:0]         month_o;
  logic [4:0]         day_o;
  logic [4:0]         hour_o;
  logic [5:0]         minute_o;
  logic [5:0]         second_o;
  logic [6:0]         centis_o;
  logic [6:0]         hundred_micros_o;
  logic [6:0]         micros_o;
  logic               range_error_o;

  stamp_t      stamps_due[$];     // expected output beats, oldest first
  row_t        directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_asked = 0;   // bumped by the stimulus, served by the receiver
  int unsigned quiet_cycles = 0;

  epoch_seconds_to_calendar_stamp u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .epoch_seconds_i  (epoch_seconds_i),
    .micro_in_i       (micro_in_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .year_o           (year_o),
    .month_o          (month_o),
    .day_o            (day_o),
    .hour_o           (hour_o),
    .minute_o         (minute_o),
    .second_o         (second_o),
    .centis_o         (centis_o),
    .hundred_micros_o (hundred_micros_o),
    .micros_o         (micros_o),
    .range_error_o    (range_error_o)
  );

  always #6 clk_i = ~clk_i;

  // Calendar predictor. Seconds are split by floor division so that instants
  // before 1970 land on the right day with a non-negative second of day. The
  // day count is then rebased to 0000-03-01, so the leap day closes each year
  // and a 400-year cycle (146097 days) repeats exactly.
  function automatic stamp_t calendar_of(input logic signed [38:0] secs,
                                         input logic [19:0] us);
    stamp_t      r;
    longint      s;
    longint      day_no;
    longint      sod;
    longint      from_march;
    longint      cycle400;
    longint      day_in_cycle;
    longint      yr_in_cycle;
    longint      day_in_yr;
    longint      mar_month;
    longint      yr;
    int unsigned u;
    r = '0;
    s = secs;
    if (s < SecLow || s > SecHigh) begin
      r.range_error = 1'b1;
      return r;
    end
    day_no = s / SecsPerDay;
    sod    = s % SecsPerDay;
    if (sod < 0) begin
      sod    += SecsPerDay;
      day_no -= 1;
    end
    from_march   = day_no + 719468;
    cycle400     = from_march / 146097;
    day_in_cycle = from_march - cycle400 * 146097;
    // Every fourth year leaps, bar centuries, bar the fourth century
    yr_in_cycle  = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                    - day_in_cycle / 146096) / 365;
    day_in_yr    = day_in_cycle - (365 * yr_in_cycle + yr_in_cycle / 4 - yr_in_cycle / 100);
    mar_month    = (5 * day_in_yr + 2) / 153;
    // January and February belong to the following civil year
    yr           = yr_in_cycle + cycle400 * 400 + ((mar_month >= 10) ? 1 : 0);
    r.year   = 14'(yr);
    r.month  = 4'((mar_month < 10) ? mar_month + 3 : mar_month - 9);
    r.day    = 5'(day_in_yr - (153 * mar_month + 2) / 5 + 1);
    r.hour   = 5'(sod / 3600);
    r.minute = 6'((sod % 3600) / 60);
    r.second = 6'(sod % 60);
    // Oversized microsecond counts clamp to the last microsecond of the second
    u = (us > MicroMax) ? int'(MicroMax) : int'(us);
    r.centis         = 7'(u / 10000);
    r.hundred_micros = 7'((u / 100) % 100);
    r.micros         = 7'(u % 100);
    return r;
  endfunction

  function automatic stamp_t make_stamp(input int yr, input int mo, input int dy,
                                        input int hh, input int mm, input int ss,
                                        input int cs, input int hm, input int mu,
                                        input int err);
    stamp_t r;
    r = {14'(yr), 4'(mo), 5'(dy), 5'(hh), 6'(mm), 6'(ss), 7'(cs), 7'(hm), 7'(mu),
         1'(err)};
    return r;
  endfunction

  task automatic add_row(input logic signed [38:0] secs, input logic [19:0] us,
                         input bit typed, input stamp_t want);
    row_t row;
    row.secs  = secs;
    row.us    = us;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one input beat, with random idle cycles ahead of it. Valid stays
  // high after the beat is taken; the next call either re-raises it with a new
  // payload or drops it, so each step sees a single assignment to valid_i.
  task automatic offer_beat(input logic signed [38:0] secs, input logic [19:0] us,
                            input stamp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i         <= 1'b1;
    epoch_seconds_i <= secs;
    micro_in_i      <= us;
    do @(posedge clk_i); while (stall_o);
    stamps_due.push_back(want);
  endtask

  // Sender goes quiet until every expected beat has come out.
  task automatic drain_pipe();
    valid_i <= 1'b0;
    while (stamps_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall at the current rate, or a long hold-off on request.
  // The hold-off is counted here, independent of the stimulus process.
  always @(posedge clk_i) begin : recv_side
    static int unsigned holds_served = 0;
    static int unsigned hold_left = 0;
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left    = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Output checker: each beat taken is matched against the oldest prediction.
  always @(posedge clk_i) begin : out_check
    stamp_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (stamps_due.size() == 0) begin
        $display("%0t: output beat with nothing expected, got year %0d month %0d day %0d",
                 $time, year_o, month_o, day_o);
        mismatches++;
      end else begin
        want = stamps_due.pop_front();
        check_field("year",           want.year,           year_o);
        check_field("month",          want.month,          month_o);
        check_field("day",            want.day,            day_o);
        check_field("hour",           want.hour,           hour_o);
        check_field("minute",         want.minute,         minute_o);
        check_field("second",         want.second,         second_o);
        check_field("centis",         want.centis,         centis_o);
        check_field("hundred_micros", want.hundred_micros, hundred_micros_o);
        check_field("micros",         want.micros,         micros_o);
        check_field("range_error",    want.range_error,    range_error_o);
      end
    end
  end

  // Watchdog: a run that stops moving beats on both sides is a failure.
  always @(posedge clk_i) begin : watchdog
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, QuietLimit);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic signed [38:0] secs;
    logic [19:0]        us;
    longint             s;
    longint             span;
    longint unsigned    raw64;
    int unsigned        pick;
    stamp_t             err_stamp;
    row_t               row;

    err_stamp = make_stamp(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    span      = longint'(SecHigh) - longint'(SecLow) + 1;

    // Directed table. Typed rows: epoch, window edges, floor at -1 s, range
    // errors (just outside, and the 39-bit extremes) and microsecond clamping.
    add_row(39'sd0, 20'd0, 1'b1, make_stamp(1970, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(SecLow, 20'd0, 1'b1, make_stamp(1, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(SecHigh, 20'd999999, 1'b1, make_stamp(9999, 12, 31, 23, 59, 59, 99, 99, 99, 0));
    add_row(SecLow - 39'sd1, 20'd123456, 1'b1, err_stamp);
    add_row(SecHigh + 39'sd1, 20'd5, 1'b1, err_stamp);
    add_row({1'b0, {38{1'b1}}}, 20'd999999, 1'b1, err_stamp);
    add_row({1'b1, {38{1'b0}}}, 20'hFFFFF, 1'b1, err_stamp);
    add_row(39'sd0, 20'hFFFFF, 1'b1, make_stamp(1970, 1, 1, 0, 0, 0, 99, 99, 99, 0));
    add_row(39'sd0, 20'd1000000, 1'b1, make_stamp(1970, 1, 1, 0, 0, 0, 99, 99, 99, 0));
    add_row(-39'sd1, 20'd0, 1'b1, make_stamp(1969, 12, 31, 23, 59, 59, 0, 0, 0, 0));
    // Predicted rows: day edges before 1970, leap days, non-leap centuries
    add_row(-39'sd86400, 20'd1, 1'b0, '0);
    add_row(-39'sd86401, 20'd10000, 1'b0, '0);
    add_row(39'sd951782400, 20'd9999, 1'b0, '0);          // 2000-02-29
    add_row(-39'sd2203977600, 20'd100, 1'b0, '0);         // 1900-02-28
    add_row(-39'sd2203891200, 20'd99, 1'b0, '0);          // 1900-03-01
    add_row(39'sd4107542399, 20'd500000, 1'b0, '0);       // 2100-02-28 last second
    add_row(39'sd68169600, 20'd654321, 1'b0, '0);         // 1972-02-29
    add_row(39'sd946684799, 20'd999998, 1'b0, '0);        // 1999-12-31 23:59:59
    add_row(39'sd1234567890, 20'd543210, 1'b0, '0);
    add_row(39'sd2147483648, 20'd10000, 1'b0, '0);
    add_row(SecLow + 39'sd86399, 20'd9999, 1'b0, '0);
    add_row(SecHigh - 39'sd31622400, 20'd100, 1'b0, '0);  // one leap year short of the top

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_beat(row.secs, row.us, row.typed ? row.want : calendar_of(row.secs, row.us));
    end
    drain_pipe();

    // Random phases: sender light / receiver heavy, then swapped, then none.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PerPhase; n++) begin
        // Long receiver hold-off while the sender keeps pushing: the pipe fills
        // and must stall its input.
        if (n == 150 && phase != 1) holds_asked++;
        raw64 = {$urandom, $urandom};
        pick  = $urandom_range(99);
        if (pick < 60) begin
          s = longint'(SecLow) + longint'(raw64 % longint'(span));
        end else if (pick < 70) begin
          s = (pick[0] ? longint'(SecLow) : longint'(SecHigh))
              + longint'($urandom_range(200)) - 100;
        end else if (pick < 88) begin
          // Midnight and its neighbours on a random day, before or after 1970
          s = (longint'($urandom_range(DaySpan - 1)) - DaysBefore) * SecsPerDay
              + longint'($urandom_range(4)) - 2;
        end else begin
          s = longint'(raw64);  // any 39-bit pattern, mostly inside the window
        end
        secs = s[38:0];
        us   = ($urandom_range(99) < 15) ? 20'($urandom) : 20'($urandom_range(999999));
        offer_beat(secs, us, calendar_of(secs, us));
      end
      drain_pipe();
    end

    repeat (NumStages + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
